[rtl/core/ssid_pkg.sv]
// shared types and constants for the sorted set insert/delete block
// no dependencies; compiled first

package ssid_pkg;

   // field widths fixed by the item formats
   localparam int VALUE_W = 32;
   localparam int FUNC_W = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W = 7;

   // default number of cells in the chain
   localparam int CAPACITY_DEF = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // operation codes of an input item
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_DUMP   = 2'd2
   } func_type;

   // status codes of a result item
   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_REMOVED   = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_ENTRY     = 3'd5,
      STAT_EMPTY     = 3'd6
   } status_type;

   // what every cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   // control broadcast from the sequencer to all cells
   typedef struct packed {
      cell_op_type op;
      value_type   key;
   } cell_ctl_type;

endpackage

[rtl/core/ssid_req_if.sv]
// request channel: valid/ready handshake carrying func and value
// depends on ssid_pkg

interface ssid_req_if;
   import ssid_pkg::*;

   logic      valid;
   logic      ready;
   func_type  func;
   value_type value;

   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

[rtl/core/ssid_rsp_if.sv]
// response channel: valid/ready handshake carrying status, value, count, last
// depends on ssid_pkg

interface ssid_rsp_if;
   import ssid_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   value_type          entry_value;
   logic [COUNT_W-1:0] entry_count;
   logic               last;

   modport source (output valid, output status, output entry_value, output entry_count,
                   output last, input ready);
   modport sink (input valid, input status, input entry_value, input entry_count,
                 input last, output ready);
endinterface

[rtl/core/ssid_cell.sv]
// one cell of the sorted chain: holds one entry, compares it with the key,
// and takes its neighbor's entry on insert, delete or rotate; uses ssid_pkg

module ssid_cell #(
   parameter int CAPACITY = ssid_pkg::CAPACITY_DEF,
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  ssid_pkg::cell_ctl_type          ctl,
   input  logic [$clog2(CAPACITY+1)-1:0]   count,
   input  ssid_pkg::value_type             left_value,
   input  logic                            left_lt,
   input  ssid_pkg::value_type             right_value,
   input  ssid_pkg::value_type             wrap_value,
   output ssid_pkg::value_type             entry,
   output logic                            lt,
   output logic                            eq
);
   import ssid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(INDEX + 1);

   value_type entry_ff;
   value_type entry_in;
   logic      valid;
   logic      tail;

   // occupancy of this cell follows from the fill count
   assign valid = IDX < count;
   assign tail = NEXT_IDX == count;

   // compare against the broadcast key
   assign lt = valid && (entry_ff < ctl.key);
   assign eq = valid && (entry_ff == ctl.key);

   // next entry: keep, shift right, shift left or rotate
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if ((IDX <= count) && !lt) begin
               entry_in = left_lt ? ctl.key : left_value;
            end
         end
         CELL_DELETE: begin
            if (valid && !lt) begin
               entry_in = right_value;
            end
         end
         CELL_ROTATE: begin
            if (valid) begin
               entry_in = tail ? wrap_value : right_value;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[rtl/core/ssid_chain.sv]
// row of ssid_cell instances with neighbor links and the match reduction
// depends on ssid_pkg and ssid_cell

module ssid_chain #(
   parameter int CAPACITY = ssid_pkg::CAPACITY_DEF
) (
   input  logic                            clock,
   input  ssid_pkg::cell_ctl_type          ctl,
   input  logic [$clog2(CAPACITY+1)-1:0]   count,
   output ssid_pkg::value_type             head_value,
   output logic                            any_eq
);
   import ssid_pkg::*;

   value_type           ents [CAPACITY];
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;

   // cells linked to their left and right neighbors; an end cell uses its own entry on its open side
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type left_v;
      value_type right_v;
      logic      left_l;

      if (i == 0) begin : g_first
         assign left_v = ents[0];
         assign left_l = 1'b1;
      end else begin : g_inner
         assign left_v = ents[i-1];
         assign left_l = lt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_v = ents[i];
      end else begin : g_mid
         assign right_v = ents[i+1];
      end

      ssid_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count),
         .left_value  (left_v),
         .left_lt     (left_l),
         .right_value (right_v),
         .wrap_value  (ents[0]),
         .entry       (ents[i]),
         .lt          (lt_vec[i]),
         .eq          (eq_vec[i])
      );
   end

   // the head cell feeds the dump stream
   assign head_value = ents[0];
   assign any_eq = |eq_vec;

endmodule

[rtl/core/sorted_set_insert_delete.sv]
// Sorted set of distinct signed 32-bit values held in a chain of CAPACITY
// compare-and-shift cells. Insert and delete items each give one result with the
// new count; a request is taken whenever the output register
// is free or being drained. A dump item gives max(count,1) results,
// one per cycle while the response side is ready: the chain rotates one cell
// per cycle and the head cell feeds the output, so requests wait until the last
// entry is out. An unused func code is taken and gives no result. No clearing
// pass is needed after reset; cells beyond the fill count are never read.
// Depends on ssid_pkg, ssid_req_if, ssid_rsp_if, ssid_chain.

module sorted_set_insert_delete #(
   parameter int CAPACITY = ssid_pkg::CAPACITY_DEF
) (
   input logic        clock,
   input logic        reset,
   ssid_req_if.sink   req_ch,
   ssid_rsp_if.source rsp_ch
);
   import ssid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   value_type          value_ff, value_in;
   logic [COUNT_W-1:0] rcount_ff, rcount_in;
   logic               last_ff, last_in;

   cell_ctl_type ctl;
   value_type    head_value;
   logic         any_eq;
   logic         slot_free;
   logic         accept;
   logic         dump_last;

   // cell chain
   ssid_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .count      (count_ff),
      .head_value (head_value),
      .any_eq     (any_eq)
   );

   // handshake
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept = req_ch.valid && req_ch.ready;
   assign dump_last = CNT_W'(idx_ff + CNT_ONE) == count_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in = status_ff;
      value_in = value_ff;
      rcount_in = rcount_ff;
      last_in = last_ff;
      ctl.op = CELL_HOLD;
      ctl.key = req_ch.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.func)
                  FUNC_INSERT: begin
                     rsp_valid_in = 1'b1;
                     value_in = req_ch.value;
                     last_in = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        status_in = STAT_FULL;
                     end else if (any_eq) begin
                        status_in = STAT_DUPLICATE;
                     end else begin
                        status_in = STAT_INSERTED;
                        ctl.op = CELL_INSERT;
                        count_in = CNT_W'(count_ff + CNT_ONE);
                     end
                     rcount_in = COUNT_W'(count_in);
                  end
                  FUNC_DELETE: begin
                     rsp_valid_in = 1'b1;
                     value_in = req_ch.value;
                     last_in = 1'b1;
                     if (any_eq) begin
                        status_in = STAT_REMOVED;
                        ctl.op = CELL_DELETE;
                        count_in = CNT_W'(count_ff - CNT_ONE);
                     end else begin
                        status_in = STAT_NOT_FOUND;
                     end
                     rcount_in = COUNT_W'(count_in);
                  end
                  FUNC_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in = STAT_EMPTY;
                        value_in = '0;
                        rcount_in = '0;
                        last_in = 1'b1;
                     end else begin
                        state_in = ST_DUMP;
                        idx_in = '0;
                     end
                  end
                  default: begin
                     // unused code: item taken, nothing emitted
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            // one entry per cycle from the head cell while the output slot is free, chain rotates under it
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in = STAT_ENTRY;
               value_in = head_value;
               rcount_in = COUNT_W'(count_ff);
               last_in = dump_last;
               ctl.op = CELL_ROTATE;
               idx_in = CNT_W'(idx_ff + CNT_ONE);
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff <= value_in;
      rcount_ff <= rcount_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.entry_value = value_ff;
   assign rsp_ch.entry_count = rcount_ff;
   assign rsp_ch.last = last_ff;

endmodule
